// ===== sv/chr_pkg.sv =====
// Shared types, codes and field widths of the chained hash record table.
// Used by the controller, the datapath and the top level; depends on nothing.
package chr_pkg;

    localparam int MAX_BUCKETS_DEF = 32;
    localparam int POOL_NODES_DEF  = 64;

    localparam int CFG_W      = 6;
    localparam int KEY_W      = 31;
    localparam int HANDLE_W   = 32;
    localparam int AGE_W      = 8;
    localparam int BKT_OUT_W  = 5;
    localparam int BIT_CNT_W  = 5;
    localparam int IN_DATA_W  = 136;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_USER_W = 2;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 6'd20;

    typedef logic [1:0] action_t;
    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_SEARCH = 2'd1;
    localparam action_t ACT_UPDATE = 2'd2;

    typedef logic [2:0] choice_t;
    localparam choice_t FLD_NAME      = 3'd0;
    localparam choice_t FLD_AGE       = 3'd1;
    localparam choice_t FLD_CONDITION = 3'd2;
    localparam choice_t FLD_PLAN      = 3'd3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SRC_IN   = 2'd0,
        SRC_RAM  = 2'd1,
        SRC_MOD  = 2'd2,
        SRC_ZERO = 2'd3
    } src_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] name;
        logic [AGE_W-1:0]    age;
        logic [HANDLE_W-1:0] condition;
        logic [HANDLE_W-1:0] plan;
    } record_t;

    typedef struct packed {
        logic    load_in;
        logic    div_step;
        logic    take_head;
        logic    take_next;
        logic    wr_node;
        logic    wr_link;
        logic    wr_upd;
        logic    res_load;
        status_t res_status;
        src_t    res_src;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic    div_last;
        logic    full;
        logic    head_valid;
        logic    key_match;
        logic    next_valid;
        logic    choice_ok;
        action_t act;
        logic    out_free;
    } sts_t;

endpackage

// ===== sv/chr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for every store of the hash table datapath.
module chr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/chr_ctrl.sv =====
// Controller state machine of the chained hash record table.
// Depends on chr_pkg; drives the datapath through cmd_t and watches sts_t.
module chr_ctrl
    import chr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_BKT  = 8'b0000_0100,
        S_DISP = 8'b0000_1000,
        S_LINK = 8'b0001_0000,
        S_RD   = 8'b0010_0000,
        S_CHK  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = ST_NOT_FOUND;
        cmd.res_src    = SRC_ZERO;
        s_tready       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_BKT;
                end
            end
            S_BKT: begin
                // Bucket address is on the head and tail memories this cycle.
                state_next = S_DISP;
            end
            S_DISP: begin
                unique case (sts.act) inside
                    ACT_INSERT: begin
                        if (sts.full) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_FULL;
                            state_next     = S_OUT;
                        end else begin
                            cmd.wr_node = 1'b1;
                            state_next  = S_LINK;
                        end
                    end
                    ACT_SEARCH, ACT_UPDATE: begin
                        if (sts.head_valid) begin
                            cmd.take_head = 1'b1;
                            state_next    = S_RD;
                        end else begin
                            cmd.res_load = 1'b1;
                            state_next   = S_OUT;
                        end
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        state_next   = S_OUT;
                    end
                endcase
            end
            S_LINK: begin
                cmd.wr_link    = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_src    = SRC_IN;
                state_next     = S_OUT;
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (sts.key_match) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_OUT;
                    if (sts.act == ACT_SEARCH) begin
                        cmd.res_status = ST_OK;
                        cmd.res_src    = SRC_RAM;
                    end else if (sts.choice_ok) begin
                        cmd.wr_upd     = 1'b1;
                        cmd.res_status = ST_OK;
                        cmd.res_src    = SRC_MOD;
                    end else begin
                        cmd.res_status = ST_INVALID;
                        cmd.res_src    = SRC_RAM;
                    end
                end else if (sts.next_valid) begin
                    cmd.take_next = 1'b1;
                    state_next    = S_RD;
                end else begin
                    cmd.res_load = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/chr_dp.sv =====
// Datapath of the chained hash record table: bucket remainder unit, bucket and node
// memories, chain pointer, result and output registers. Depends on chr_pkg and chr_ram.
module chr_dp
    import chr_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = POOL_NODES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int BKT_AW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NODE_AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int CNT_W   = $clog2(POOL_NODES + 1);
    localparam int LINK_W  = NODE_AW + 1;
    localparam int REC_W   = $bits(record_t);

    logic [CFG_W-1:0]     bucket_count_reg;
    logic [CFG_W-1:0]     divisor;
    action_t              act_reg;
    choice_t              choice_reg;
    record_t              in_rec_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [BIT_CNT_W-1:0] bit_reg;
    logic [CFG_W:0]       trial;
    logic [CFG_W:0]       trial_diff;
    logic [BKT_AW-1:0]    bkt_addr;
    logic [MAX_BUCKETS-1:0] head_valid_reg;
    logic                 head_valid_cur;
    logic [CNT_W-1:0]     nodes_used_reg;
    logic [NODE_AW-1:0]   node_addr;
    logic [NODE_AW-1:0]   cur_reg;
    logic [NODE_AW-1:0]   head_rdata;
    logic [NODE_AW-1:0]   tail_rdata;
    logic [LINK_W-1:0]    next_rdata;
    record_t              rec_rdata;
    record_t              rec_mod;
    logic                 head_we;
    logic                 next_we;
    logic [NODE_AW-1:0]   next_waddr;
    logic [LINK_W-1:0]    next_wdata;
    logic                 rec_we;
    logic [NODE_AW-1:0]   rec_waddr;
    record_t              rec_wdata;
    status_t              res_status_reg;
    record_t              res_rec_reg;
    logic                 m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_USER_W-1:0] m_user_reg;

    // Register write and divisor clamping to 1..MAX_BUCKETS.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= BUCKET_COUNT_RESET;
        end else if (cfg_we) begin
            bucket_count_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (bucket_count_reg == '0) begin
            divisor = CFG_W'(1);
        end else if ({3'b000, bucket_count_reg} > 9'(MAX_BUCKETS)) begin
            divisor = CFG_W'(MAX_BUCKETS);
        end else begin
            divisor = bucket_count_reg;
        end
    end

    // Input capture.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg              <= s_tuser[1:0];
            choice_reg           <= s_tuser[4:2];
            in_rec_reg.key       <= s_tdata[30:0];
            in_rec_reg.name      <= s_tdata[62:31];
            in_rec_reg.age       <= s_tdata[70:63];
            in_rec_reg.condition <= s_tdata[102:71];
            in_rec_reg.plan      <= s_tdata[134:103];
        end
    end

    // Restoring remainder, one key bit per cycle from the top.
    assign trial      = {rem_reg, in_rec_reg.key[bit_reg]};
    assign trial_diff = trial - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            rem_reg <= '0;
            bit_reg <= BIT_CNT_W'(KEY_W - 1);
        end else if (cmd.div_step) begin
            rem_reg <= (trial >= {1'b0, divisor}) ? trial_diff[CFG_W-1:0]
                                                  : trial[CFG_W-1:0];
            bit_reg <= bit_reg - 1'b1;
        end
    end

    assign bkt_addr       = BKT_AW'(rem_reg);
    assign head_valid_cur = head_valid_reg[bkt_addr];
    assign node_addr      = nodes_used_reg[NODE_AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= '0;
            nodes_used_reg <= '0;
        end else if (cmd.wr_link) begin
            head_valid_reg[bkt_addr] <= 1'b1;
            nodes_used_reg           <= nodes_used_reg + 1'b1;
        end
    end

    // Chain pointer.
    always_ff @(posedge aclk) begin
        if (cmd.take_head) begin
            cur_reg <= head_rdata;
        end else if (cmd.take_next) begin
            cur_reg <= next_rdata[NODE_AW-1:0];
        end
    end

    // Write ports of the node and bucket memories.
    assign head_we    = cmd.wr_link && !head_valid_cur;
    assign next_we    = cmd.wr_node || (cmd.wr_link && head_valid_cur);
    assign next_waddr = cmd.wr_node ? node_addr : tail_rdata;
    assign next_wdata = cmd.wr_node ? '0 : {1'b1, node_addr};
    assign rec_we     = cmd.wr_node || cmd.wr_upd;
    assign rec_waddr  = cmd.wr_node ? node_addr : cur_reg;
    assign rec_wdata  = cmd.wr_node ? in_rec_reg : rec_mod;

    chr_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_BUCKETS)) u_head_ram (
        .aclk    (aclk),
        .wr_en   (head_we),
        .wr_addr (bkt_addr),
        .wr_data (node_addr),
        .rd_addr (bkt_addr),
        .rd_data (head_rdata)
    );

    chr_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_BUCKETS)) u_tail_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_link),
        .wr_addr (bkt_addr),
        .wr_data (node_addr),
        .rd_addr (bkt_addr),
        .rd_data (tail_rdata)
    );

    chr_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_next_ram (
        .aclk    (aclk),
        .wr_en   (next_we),
        .wr_addr (next_waddr),
        .wr_data (next_wdata),
        .rd_addr (cur_reg),
        .rd_data (next_rdata)
    );

    chr_ram #(.WIDTH(REC_W), .DEPTH(POOL_NODES)) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (rec_we),
        .wr_addr (rec_waddr),
        .wr_data (rec_wdata),
        .rd_addr (cur_reg),
        .rd_data (rec_rdata)
    );

    // Field replacement for an update.
    always_comb begin
        rec_mod = rec_rdata;
        case (choice_reg)
            FLD_NAME:      rec_mod.name      = in_rec_reg.name;
            FLD_AGE:       rec_mod.age       = in_rec_reg.age;
            FLD_CONDITION: rec_mod.condition = in_rec_reg.condition;
            FLD_PLAN:      rec_mod.plan      = in_rec_reg.plan;
            default:       rec_mod           = rec_rdata;
        endcase
    end

    // Result staging.
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            unique case (cmd.res_src)
                SRC_IN:   res_rec_reg <= in_rec_reg;
                SRC_RAM:  res_rec_reg <= rec_rdata;
                SRC_MOD:  res_rec_reg <= rec_mod;
                SRC_ZERO: res_rec_reg <= '0;
                default:  res_rec_reg <= '0;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {4'b0000, res_rec_reg.plan, res_rec_reg.condition,
                           res_rec_reg.age, res_rec_reg.name, res_rec_reg.key,
                           rem_reg[BKT_OUT_W-1:0]};
            m_user_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign sts.div_last   = (bit_reg == '0);
    assign sts.full       = (nodes_used_reg >= CNT_W'(POOL_NODES));
    assign sts.head_valid = head_valid_cur;
    assign sts.key_match  = (rec_rdata.key == in_rec_reg.key);
    assign sts.next_valid = next_rdata[LINK_W-1];
    assign sts.choice_ok  = (choice_reg <= FLD_PLAN);
    assign sts.act        = act_reg;
    assign sts.out_free   = !m_valid_reg || m_tready;

endmodule

// ===== sv/chained_hash_record_table.sv =====
// Top level of the chained hash record table: controller plus datapath.
// Depends on chr_pkg, chr_ctrl, chr_dp and, through the datapath, chr_ram.
//
//   Channel   Direction  Handshake            Payload
//   config    in         cfg_we               cfg_wdata = bucket_count
//   request   in         s_tvalid / s_tready  s_tuser, s_tdata (one word per operation)
//   result    out        m_tvalid / m_tready  m_tuser, m_tdata (one word per operation)
//
// An operation is accepted, the bit-serial remainder unit walks the key bits to pick the
// bucket, and the bucket memories are looked up. An insert then writes the node and links
// it into the chain; a search or update visits the chain node by node, each node being
// fetched from the registered-read record memory, so a lookup takes longer the further
// down the chain its key lies, and a chain can be as long as the pool.
// Reset clears the controller, the bucket head valid flags and the node count at once;
// node storage needs no clearing pass. A stalled result waits in the output register
// while the next word is accepted and worked on.
module chained_hash_record_table
    import chr_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = POOL_NODES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // key[30:0], name_handle[62:31], age_value[70:63], condition_handle[102:71],
    // plan_handle[134:103], zero pad[135]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action[1:0], field_choice[4:2]
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // bucket_index[4:0], found_key[35:5], found_name[67:36], found_age[75:68],
    // found_condition[107:76], found_plan[139:108], zero pad[143:140]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [OUT_USER_W-1:0] m_tuser
);

    cmd_t cmd;
    sts_t sts;

    // The controller sequences each operation; it sees only the request valid and status flags.
    chr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds every store, the remainder unit and the output register.
    chr_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .POOL_NODES  (POOL_NODES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    // A node is never allocated once the pool is used up.
    a_no_alloc_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_node |-> !sts.full)
        else $error("node allocated from an exhausted pool");

    // The chain walk only follows links that were written.
    a_follow_valid_link: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_next |-> sts.next_valid)
        else $error("chain walk followed an unwritten link");

    // After taking a word the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while an operation is in progress");

    // A result only appears while the block was working on a word.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result produced while the block was idle");

endmodule

// ===== sim/chained_hash_record_table_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the chained hash record table: stream-driven requests,
// a scoreboard class that predicts each result word, and random back-pressure.
// Depends on chr_pkg and the chained_hash_record_table top level only.
module chained_hash_record_table_test;
    import chr_pkg::*;

    localparam int BUCKETS = MAX_BUCKETS_DEF;
    localparam int POOL    = POOL_NODES_DEF;
    localparam int PHASE_WORDS = 200;
    localparam int HOLD_CYCLES = 800;

    // The action field is two bits wide, so one code is left without a meaning.
    localparam action_t ACT_UNUSED = action_t'(2'd3);
    localparam choice_t FLD_BAD_LO = choice_t'(3'd4);
    localparam choice_t FLD_BAD_HI = choice_t'(3'd7);

    typedef struct {
        action_t          action;
        logic [KEY_W-1:0] key;
        logic [31:0]      name;
        logic [7:0]       age;
        logic [31:0]      condition;
        logic [31:0]      plan;
        choice_t          choice;
    } table_request_t;

    typedef struct {
        status_t     status;
        logic [4:0]  bucket;
        record_t     rec;
    } table_result_t;

    // Keeps its own copy of the chains and the node pool and predicts one result word
    // per accepted request; results are matched in order against that prediction.
    class table_scoreboard;
        int unsigned   divisor;
        bit            head_valid [BUCKETS];
        int            head [BUCKETS];
        int            tail [BUCKETS];
        record_t       node [POOL];
        bit            next_valid [POOL];
        int            next_node [POOL];
        int unsigned   used;
        table_result_t pending [$];
        int unsigned   errors;
        int unsigned   checked;
        int unsigned   status_count [4];
        int unsigned   longest_walk;

        function new();
            divisor = 20;
            used = 0;
            errors = 0;
            checked = 0;
            longest_walk = 0;
            foreach (head_valid[i]) head_valid[i] = 1'b0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        // Zero behaves as one bucket and anything past the table size as the full table.
        function void set_bucket_count(logic [CFG_W-1:0] value);
            if (value == '0) divisor = 1;
            else if (int'(value) > BUCKETS) divisor = BUCKETS;
            else divisor = 32'(value);
        endfunction

        function bit find_first(int bkt, logic [KEY_W-1:0] key, output int idx);
            int cur;
            idx = 0;
            if (!head_valid[bkt]) return 1'b0;
            cur = head[bkt];
            for (int steps = 1; steps <= POOL; steps++) begin
                if (steps > longest_walk) longest_walk = steps;
                if (node[cur].key == key) begin
                    idx = cur;
                    return 1'b1;
                end
                if (!next_valid[cur]) return 1'b0;
                cur = next_node[cur];
            end
            return 1'b0;
        endfunction

        function void note_request(table_request_t rq);
            table_result_t res;
            int bkt;
            int idx;
            bkt = rq.key % divisor;
            res.status = ST_NOT_FOUND;
            res.bucket = bkt[4:0];
            res.rec = '0;
            case (rq.action)
                ACT_INSERT: begin
                    if (used >= POOL) begin
                        res.status = ST_FULL;
                    end else begin
                        idx = used;
                        used++;
                        node[idx] = {rq.key, rq.name, rq.age, rq.condition, rq.plan};
                        next_valid[idx] = 1'b0;
                        if (!head_valid[bkt]) begin
                            head_valid[bkt] = 1'b1;
                            head[bkt] = idx;
                        end else begin
                            next_node[tail[bkt]] = idx;
                            next_valid[tail[bkt]] = 1'b1;
                        end
                        tail[bkt] = idx;
                        res.status = ST_OK;
                        res.rec = node[idx];
                    end
                end
                ACT_SEARCH: begin
                    if (find_first(bkt, rq.key, idx)) begin
                        res.status = ST_OK;
                        res.rec = node[idx];
                    end
                end
                ACT_UPDATE: begin
                    if (find_first(bkt, rq.key, idx)) begin
                        res.status = ST_OK;
                        case (rq.choice)
                            FLD_NAME:      node[idx].name = rq.name;
                            FLD_AGE:       node[idx].age = rq.age;
                            FLD_CONDITION: node[idx].condition = rq.condition;
                            FLD_PLAN:      node[idx].plan = rq.plan;
                            default:       res.status = ST_INVALID;
                        endcase
                        res.rec = node[idx];
                    end
                end
                default: ;
            endcase
            pending.push_back(res);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] status, logic [4:0] bucket, record_t rec);
            table_result_t want;
            if (pending.size() == 0) begin
                $error("result word with no request outstanding: status %0d, bucket %0d",
                       status, bucket);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            status_count[int'(want.status)]++;
            compare_field("status", 32'(want.status), 32'(status));
            compare_field("bucket_index", 32'(want.bucket), 32'(bucket));
            compare_field("found_key", 32'(want.rec.key), 32'(rec.key));
            compare_field("found_name", want.rec.name, rec.name);
            compare_field("found_age", 32'(want.rec.age), 32'(rec.age));
            compare_field("found_condition", want.rec.condition, rec.condition);
            compare_field("found_plan", want.rec.plan, rec.plan);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    table_scoreboard sb;
    logic [KEY_W-1:0] known_keys [24];
    bit               idle_on = 1'b1;
    int               settings_seen = 1;

    chained_hash_record_table u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Bus monitor. Both handshakes are sampled at the clock edge, before any driver
    // updates land, and results are checked ahead of noting a request of the same edge.
    always @(posedge aclk) begin : bus_monitor
        table_request_t rq;
        record_t        rec;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                rec.key       = m_tdata[35:5];
                rec.name      = m_tdata[67:36];
                rec.age       = m_tdata[75:68];
                rec.condition = m_tdata[107:76];
                rec.plan      = m_tdata[139:108];
                sb.check_result(m_tuser, m_tdata[4:0], rec);
            end
            if (s_tvalid && s_tready) begin
                rq.key       = s_tdata[30:0];
                rq.name      = s_tdata[62:31];
                rq.age       = s_tdata[70:63];
                rq.condition = s_tdata[102:71];
                rq.plan      = s_tdata[134:103];
                rq.action    = s_tuser[1:0];
                rq.choice    = s_tuser[4:2];
                sb.note_request(rq);
            end
        end
    end

    // Mostly back-to-back, sometimes a few cycles, now and then a long pause.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 98) return $urandom_range(5, 20);
        return $urandom_range(30, 80);
    endfunction

    function automatic table_request_t make_request(action_t action, logic [KEY_W-1:0] key,
                                                    logic [31:0] name, logic [7:0] age,
                                                    logic [31:0] condition,
                                                    logic [31:0] plan, choice_t choice);
        table_request_t rq;
        rq.action = action;
        rq.key = key;
        rq.name = name;
        rq.age = age;
        rq.condition = condition;
        rq.plan = plan;
        rq.choice = choice;
        return rq;
    endfunction

    // Keys come mostly from a small set so that lookups hit and chains grow; the rest
    // are drawn from the whole key range.
    function automatic table_request_t random_request();
        table_request_t rq;
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) rq.action = ACT_INSERT;
        else if (r < 55) rq.action = ACT_SEARCH;
        else if (r < 97) rq.action = ACT_UPDATE;
        else rq.action = ACT_UNUSED;
        if ($urandom_range(0, 99) < 80) rq.key = known_keys[$urandom_range(0, 23)];
        else rq.key = KEY_W'($urandom);
        rq.name = $urandom;
        rq.age = 8'($urandom_range(0, 255));
        rq.condition = $urandom;
        rq.plan = $urandom;
        if ($urandom_range(0, 99) < 85) rq.choice = choice_t'($urandom_range(0, 3));
        else rq.choice = choice_t'($urandom_range(4, 7));
        return rq;
    endfunction

    // Called at a clock edge. The word is held until the block takes it; valid drops
    // only when a gap follows, so back-to-back words keep it high.
    task automatic send_request(table_request_t rq);
        int gap;
        s_tdata <= {1'b0, rq.plan, rq.condition, rq.age, rq.name, rq.key};
        s_tuser <= {rq.choice, rq.action};
        s_tvalid <= 1'b1;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        gap = idle_on ? idle_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // The register is only written with the table idle: every result word is in and a
    // few more cycles have passed. One edge is let by first, so a word taken at the
    // calling edge is already noted by the monitor.
    task automatic write_bucket_count(logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_bucket_count(value);
        settings_seen++;
    endtask

    // Result side. Random stalls after each word while idling is on, and one long hold-off
    // once enough results are in, so the output register and the request path both back up.
    initial begin : result_sink
        bit held;
        int gap;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        m_tready <= 1'b1;
        forever begin
            @(negedge aclk);
            while (!(m_tvalid && m_tready)) @(negedge aclk);
            @(posedge aclk);
            if (!held && sb.checked >= 500) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                gap = idle_on ? idle_length() : 0;
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] phase_count [7];
        sb = new();
        phase_count = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd7, 6'd13, 6'd20};
        phase_count[5] = CFG_W'($urandom_range(2, 31));
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        known_keys[0] = '0;
        known_keys[1] = '1;
        for (int i = 2; i < 24; i++) begin
            if (i < 14) known_keys[i] = KEY_W'($urandom_range(0, 200));
            else known_keys[i] = KEY_W'($urandom);
        end

        // Directed words at the reset bucket count of 20. Keys 0, 20 and 40 share bucket zero;
        // inserts of 0, 20 and 0 again build a chain with a duplicate key, and 40 is only searched.
        send_request(make_request(ACT_SEARCH, 31'd5, '0, '0, '0, '0, FLD_NAME));
        send_request(make_request(ACT_UPDATE, 31'd5, '1, '1, '1, '1, FLD_AGE));
        send_request(make_request(ACT_INSERT, 31'd0, '0, '0, '0, '0, FLD_NAME));
        send_request(make_request(ACT_INSERT, '1, '1, 8'hFF, '1, '1, FLD_BAD_HI));
        send_request(make_request(ACT_INSERT, 31'd20, 32'h1234_5678, 8'd42,
                                  32'hCAFE_0001, 32'h0BAD_F00D, FLD_NAME));
        send_request(make_request(ACT_INSERT, 31'd0, 32'h5555_AAAA, 8'd99,
                                  32'hAAAA_5555, 32'h0F0F_F0F0, FLD_NAME));
        send_request(make_request(ACT_SEARCH, 31'd0, '0, '0, '0, '0, FLD_NAME));
        send_request(make_request(ACT_SEARCH, 31'd20, '0, '0, '0, '0, FLD_NAME));
        send_request(make_request(ACT_SEARCH, 31'd40, '0, '0, '0, '0, FLD_NAME));
        send_request(make_request(ACT_UPDATE, 31'd0, 32'hDEAD_BEEF, '0, '0, '0, FLD_NAME));
        send_request(make_request(ACT_UPDATE, 31'd0, '0, 8'd128, '0, '0, FLD_AGE));
        send_request(make_request(ACT_UPDATE, 31'd0, '0, '0, 32'h8000_0001, '0,
                                  FLD_CONDITION));
        send_request(make_request(ACT_UPDATE, 31'd0, '0, '0, '0, 32'h7FFF_FFFE, FLD_PLAN));
        send_request(make_request(ACT_UPDATE, 31'd0, '1, '1, '1, '1, FLD_BAD_LO));
        send_request(make_request(ACT_UPDATE, 31'd20, '1, '1, '1, '1, FLD_BAD_HI));
        send_request(make_request(ACT_SEARCH, 31'd0, '0, '0, '0, '0, FLD_NAME));
        // An absent key answers not found even with an invalid field choice.
        send_request(make_request(ACT_UPDATE, 31'd999, '1, '1, '1, '1, choice_t'(3'd5)));
        send_request(make_request(ACT_UNUSED, '1, '1, '1, '1, '1, FLD_BAD_HI));
        send_request(make_request(ACT_SEARCH, '1, '0, '0, '0, '0, FLD_NAME));
        send_request(make_request(ACT_UPDATE, '1, '0, 8'd0, '0, '0, FLD_AGE));

        // Random phases, one per bucket count. The extremes come first: one bucket puts
        // every record on a single long chain. Every third phase runs without idling.
        for (int p = 0; p < 7; p++) begin
            write_bucket_count(phase_count[p]);
            idle_on = (p % 3 != 1);
            repeat (PHASE_WORDS) send_request(random_request());
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("Checked %0d result words under %0d bucket counts: %0d ok, %0d not found,",
                 sb.checked, settings_seen, sb.status_count[0], sb.status_count[1]);
        $display("%0d pool full, %0d invalid field; %0d of %0d nodes used, longest walk %0d.",
                 sb.status_count[2], sb.status_count[3], sb.used, POOL, sb.longest_walk);
        if (sb.errors == 0) begin
            $display("chained_hash_record_table_test OK");
        end else begin
            $display("chained_hash_record_table_test NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake; several times the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("chained_hash_record_table_test NOT OK");
        $finish;
    end

endmodule
